### src/hsv2rgb_pkg.sv
// Package for the HSV to RGB converter: field widths, fixed-point constants,
// and the hue sector encoding. No dependencies.
`default_nettype none

package hsv2rgb_pkg;

    localparam int unsigned HUE_W  = 9;
    localparam int unsigned CHAN_W = 8;
    // Chroma s*v fits 16 bits; weighted terms are at most 3901500 and fit 22 bits.
    localparam int unsigned CHROMA_W = 16;
    localparam int unsigned WEIGHT_W = 6;
    localparam int unsigned TERM_W   = 22;

    localparam logic [WEIGHT_W-1:0] DEG_PER_SECTOR = WEIGHT_W'(60);
    localparam logic [TERM_W-1:0]   TERM_LIMIT     = TERM_W'(3901500);

    // Division by 15300 is done as a multiply by ceil(2^36 / 15300) and a shift.
    // The error term times the largest dividend stays below 2^36, so it is exact.
    localparam int unsigned RECIP_W     = 23;
    localparam int unsigned RECIP_SHIFT = 36;
    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(4491470);
    localparam int unsigned PROD_W = TERM_W + RECIP_W;

    // 60-degree hue sectors, upper bounds inclusive.
    typedef enum logic [2:0] {
        SEC_RY = 3'd0,  // hue <= 60
        SEC_YG = 3'd1,  // hue <= 120
        SEC_GC = 3'd2,  // hue <= 180
        SEC_CB = 3'd3,  // hue <= 240
        SEC_BM = 3'd4,  // hue <= 300
        SEC_MR = 3'd5   // everything above, including hues of 360 and more
    } sector_t;

endpackage

`default_nettype wire

### src/hsv_to_rgb_converter_unit.sv
// Top level of the pipelined HSV to RGB converter.
// Depends on hsv2rgb_pkg for widths, constants and the sector type.
`default_nettype none

// An accepted input item passes through stages 1 to 4 in order; stage 4 drives m_*.
// One item per cycle while m_ready holds; four register stages, each holding at most
// one multiply per channel, with a valid bit per stage so bubbles are squeezed out.
// Reset (aresetn low at a clock edge) clears every stage valid bit, so no
// result is presented afterwards; the data registers are not reset.
module hsv_to_rgb_converter_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [8:0] s_hue,
    input  wire logic [7:0] s_saturation,
    input  wire logic [7:0] s_brightness,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_red,
    output logic [7:0]      m_green,
    output logic [7:0]      m_blue
);

    localparam int unsigned HW = hsv2rgb_pkg::HUE_W;
    localparam int unsigned CW = hsv2rgb_pkg::CHROMA_W;
    localparam int unsigned WW = hsv2rgb_pkg::WEIGHT_W;
    localparam int unsigned TW = hsv2rgb_pkg::TERM_W;
    localparam int unsigned PW = hsv2rgb_pkg::PROD_W;
    localparam int unsigned OW = hsv2rgb_pkg::CHAN_W;
    localparam int unsigned QL = hsv2rgb_pkg::RECIP_SHIFT;

    // Each stage may load when it is empty or when the stage after it moves on.
    // This makes every stage its own skid, and m_ready feeds back through the chain.
    logic v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic en1, en2, en3, en4;

    assign en4     = !m_valid_reg || m_ready;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;
    assign m_valid = m_valid_reg;

    // ------------------------------------------------------------------
    // Stage 1: chroma product, hue folded into a 0..60 weight, sector.
    // ------------------------------------------------------------------
    logic [HW-1:0]        hue_off;
    logic [HW-1:0]        hue_mod;
    logic [WW:0]          hm;
    logic [WW-1:0]        hue_dist;
    hsv2rgb_pkg::sector_t sector_next;

    logic [CW-1:0]        c1_reg;
    logic [WW-1:0]        w1_reg;
    logic [OW-1:0]        val1_reg;
    hsv2rgb_pkg::sector_t sec1_reg;

    // hue mod 120 for hues up to 511 by picking the multiple of 120 to remove.
    always_comb begin
        priority if (s_hue >= HW'(480)) begin
            hue_off = HW'(480);
        end else if (s_hue >= HW'(360)) begin
            hue_off = HW'(360);
        end else if (s_hue >= HW'(240)) begin
            hue_off = HW'(240);
        end else if (s_hue >= HW'(120)) begin
            hue_off = HW'(120);
        end else begin
            hue_off = HW'(0);
        end
    end

    assign hue_mod = s_hue - hue_off;
    assign hm      = hue_mod[WW:0];
    // Distance from the middle of the 120-degree span; the weight is 60 minus it.
    assign hue_dist = (hm >= {1'b0, hsv2rgb_pkg::DEG_PER_SECTOR})
                    ? WW'(hm - {1'b0, hsv2rgb_pkg::DEG_PER_SECTOR})
                    : WW'({1'b0, hsv2rgb_pkg::DEG_PER_SECTOR} - hm);

    always_comb begin
        priority if (s_hue <= HW'(60)) begin
            sector_next = hsv2rgb_pkg::SEC_RY;
        end else if (s_hue <= HW'(120)) begin
            sector_next = hsv2rgb_pkg::SEC_YG;
        end else if (s_hue <= HW'(180)) begin
            sector_next = hsv2rgb_pkg::SEC_GC;
        end else if (s_hue <= HW'(240)) begin
            sector_next = hsv2rgb_pkg::SEC_CB;
        end else if (s_hue <= HW'(300)) begin
            sector_next = hsv2rgb_pkg::SEC_BM;
        end else begin
            sector_next = hsv2rgb_pkg::SEC_MR;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            c1_reg   <= CW'(s_saturation) * CW'(s_brightness);
            w1_reg   <= hsv2rgb_pkg::DEG_PER_SECTOR - hue_dist;
            val1_reg <= s_brightness;
            sec1_reg <= sector_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: X = C * weight, C*60 and the offset M = (255*v - C) * 60.
    // The times-60 terms are shift-and-subtract.
    // ------------------------------------------------------------------
    logic [CW-1:0] v255;
    logic [CW-1:0] dmin;
    logic [TW-1:0] x2_reg, cf2_reg, m2_reg;
    hsv2rgb_pkg::sector_t sec2_reg;

    assign v255 = {val1_reg, {OW{1'b0}}} - CW'(val1_reg);
    // 255*v - s*v = v*(255-s), never negative.
    assign dmin = v255 - c1_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            x2_reg   <= TW'(c1_reg) * TW'(w1_reg);
            cf2_reg  <= (TW'(c1_reg) << 6) - (TW'(c1_reg) << 2);
            m2_reg   <= (TW'(dmin) << 6) - (TW'(dmin) << 2);
            sec2_reg <= sec1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: pick each channel's term by sector and add the offset.
    // ------------------------------------------------------------------
    logic [TW-1:0] pr, pg, pb;
    logic [TW-1:0] sr3_reg, sg3_reg, sb3_reg;

    always_comb begin
        pr = '0;
        pg = '0;
        pb = '0;
        unique case (sec2_reg)
            hsv2rgb_pkg::SEC_RY: begin
                pr = cf2_reg;
                pg = x2_reg;
            end
            hsv2rgb_pkg::SEC_YG: begin
                pr = x2_reg;
                pg = cf2_reg;
            end
            hsv2rgb_pkg::SEC_GC: begin
                pg = cf2_reg;
                pb = x2_reg;
            end
            hsv2rgb_pkg::SEC_CB: begin
                pg = x2_reg;
                pb = cf2_reg;
            end
            hsv2rgb_pkg::SEC_BM: begin
                pr = x2_reg;
                pb = cf2_reg;
            end
            hsv2rgb_pkg::SEC_MR: begin
                pr = cf2_reg;
                pb = x2_reg;
            end
            default: begin
                pr = '0;
                pg = '0;
                pb = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            sr3_reg <= pr + m2_reg;
            sg3_reg <= pg + m2_reg;
            sb3_reg <= pb + m2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: divide each sum by 15300 with a reciprocal multiply and
    // keep the quotient bits; this is also the output register.
    // ------------------------------------------------------------------
    logic [PW-1:0] qr, qg, qb;
    logic [OW-1:0] red_reg, green_reg, blue_reg;

    assign qr = PW'(sr3_reg) * PW'(hsv2rgb_pkg::RECIP_K);
    assign qg = PW'(sg3_reg) * PW'(hsv2rgb_pkg::RECIP_K);
    assign qb = PW'(sb3_reg) * PW'(hsv2rgb_pkg::RECIP_K);

    always_ff @(posedge aclk) begin
        if (en4) begin
            red_reg   <= qr[QL +: OW];
            green_reg <= qg[QL +: OW];
            blue_reg  <= qb[QL +: OW];
        end
    end

    assign m_red   = red_reg;
    assign m_green = green_reg;
    assign m_blue  = blue_reg;

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= s_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (en4) begin
                m_valid_reg <= v3_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A draining output never holds back the input.
    a_no_stall_when_draining: assert property (
        @(posedge aclk) disable iff (!aresetn) m_ready |-> s_ready
    ) else $error("input stalled while the output drains");

    // The input is refused only when every stage holds an item.
    a_stall_only_when_full: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg && m_valid_reg && !m_ready)
    ) else $error("input stalled with an empty stage");

    // The hue weight never exceeds one sector.
    a_weight_range: assert property (
        @(posedge aclk) disable iff (!aresetn)
        v1_reg |-> (w1_reg <= hsv2rgb_pkg::DEG_PER_SECTOR)
    ) else $error("hue weight out of range");

    // Channel sums stay inside the range the reciprocal divide is exact for.
    a_sum_range: assert property (
        @(posedge aclk) disable iff (!aresetn)
        v3_reg |-> (sr3_reg <= hsv2rgb_pkg::TERM_LIMIT && sg3_reg <= hsv2rgb_pkg::TERM_LIMIT
                    && sb3_reg <= hsv2rgb_pkg::TERM_LIMIT)
    ) else $error("channel sum above full scale");

    // A result left waiting stays valid, and its red and blue are not overwritten by the stage behind it.
    a_result_kept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(red_reg) && $stable(blue_reg))
    ) else $error("pending result changed");

endmodule

`default_nettype wire
